FILE: design/interval_set_table_unit_macros.svh
// ----------------------------------------------------------------------------
// interval_set_table_unit_macros
// assertion macros for the interval set table
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SET_TABLE_UNIT_MACROS_SVH
`define INTERVAL_SET_TABLE_UNIT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define IST_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// invariant checked on every rising clock edge outside reset
`define IST_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

`endif

FILE: design/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// types and constants shared by the interval set table
// ----------------------------------------------------------------------------
package ist_pkg;

   localparam int MAX_INTERVALS = 16;
   localparam int VALUE_BITS    = 32;
   localparam int IDX_BITS      = $clog2(MAX_INTERVALS);
   localparam int ADDR_BITS     = IDX_BITS + 1;
   localparam int COUNT_BITS    = 5;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_SUB   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] MEMB_NONE = 2'd0;
   localparam logic [1:0] MEMB_FULL = 2'd1;
   localparam logic [1:0] MEMB_PART = 2'd2;

   typedef struct packed {
      logic [1:0]            operation;
      logic [VALUE_BITS-1:0] start_req;
      logic [VALUE_BITS-1:0] span;
   } req_type;

   typedef struct packed {
      logic [1:0]            membership;
      logic [COUNT_BITS-1:0] interval_count;
      logic                  table_full;
   } rsp_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] first;
      logic [VALUE_BITS-1:0] last;
   } entry_type;

endpackage

FILE: design/interval_set_table_unit.sv
// ----------------------------------------------------------------------------
// interval_set_table_unit
// sorted table of disjoint intervals held in a double-banked memory
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid/req_ready    req_data   (req_type)
//  rsp       out        rsp_valid/rsp_ready    rsp_data   (rsp_type)
//
//  add and subtract stream the stored entries from one bank into the other,
//  one entry a cycle, pausing for each split or insert before an entry
//  query walks the same read port until the first entry not ending before it
//  clear and empty requests go straight to the response state; reset empties the table at once
//  a refused request leaves the old bank live; a stalled response waits in
//  its register while the next request is taken, which then waits in its
//  response state until the response has gone
// ----------------------------------------------------------------------------
`include "interval_set_table_unit_macros.svh"

module interval_set_table_unit
   import ist_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PROC   = 3'd1;
   localparam logic [2:0] ST_SPLIT  = 3'd2;
   localparam logic [2:0] ST_FINISH = 3'd3;
   localparam logic [2:0] ST_RESP   = 3'd4;

   localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_INTERVALS);
   localparam logic [VALUE_BITS-1:0] TOP = {VALUE_BITS{1'b1}};

   entry_type mem [2**ADDR_BITS];
   entry_type rd_ff;

   logic [2:0]            state_ff, state_in;
   logic                  bank_ff, bank_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] wcnt_ff, wcnt_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [1:0]            op_ff, op_in;
   logic [VALUE_BITS-1:0] s_ff, s_in, e_ff, e_in, nf_ff, nf_in, nl_ff, nl_in;
   logic                  placed_ff, placed_in, upd_ff, upd_in;
   logic [1:0]            memb_ff, memb_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  rd_en;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic                  emit;
   entry_type             emit_data;
   logic                  mem_we;
   logic [VALUE_BITS:0]   sum;
   logic [VALUE_BITS:0]   l1, nl1;
   logic                  at_end, commit;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign sum    = {1'b0, req_data.start_req} + {1'b0, req_data.span} - 1'b1;
   assign l1     = {1'b0, rd_ff.last} + 1'b1;
   assign nl1    = {1'b0, nl_ff} + 1'b1;
   assign at_end = (({{(COUNT_BITS-IDX_BITS){1'b0}}, idx_ff} + 1'b1) == total_ff);
   assign commit = upd_ff && (op_ff != OP_QUERY) && (wcnt_ff <= MAX_COUNT);
   assign mem_we = emit && (wcnt_ff < MAX_COUNT);

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      total_in     = total_ff;
      wcnt_in      = wcnt_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      nf_in        = nf_ff;
      nl_in        = nl_ff;
      placed_in    = placed_ff;
      upd_in       = upd_ff;
      memb_in      = memb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = {bank_ff, idx_ff};
      emit         = 1'b0;
      emit_data    = rd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.operation;
               s_in      = req_data.start_req;
               e_in      = sum[VALUE_BITS] ? TOP : sum[VALUE_BITS-1:0];
               nf_in     = req_data.start_req;
               nl_in     = sum[VALUE_BITS] ? TOP : sum[VALUE_BITS-1:0];
               placed_in = 1'b0;
               wcnt_in   = '0;
               idx_in    = '0;
               memb_in   = MEMB_NONE;
               upd_in    = 1'b0;
               if (req_data.operation == OP_CLEAR) begin
                  total_in = '0;
                  state_in = ST_RESP;
               end else if (req_data.span == '0) begin
                  state_in = ST_RESP;
               end else begin
                  upd_in = 1'b1;
                  if (total_ff == '0) begin
                     state_in = ST_FINISH;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = {bank_ff, {IDX_BITS{1'b0}}};
                     state_in = ST_PROC;
                  end
               end
            end
         end
         ST_PROC, ST_SPLIT: begin
            logic advance;
            advance = 1'b1;
            if (state_ff == ST_SPLIT) begin
               emit = 1'b1;
               if (op_ff == OP_SUB) begin
                  emit_data.first = e_ff + 1'b1;
               end
            end else begin
               unique case (op_ff)
                  OP_ADD: begin
                     if (placed_ff || (l1 < {1'b0, nf_ff})) begin
                        emit = 1'b1;
                     end else if ({1'b0, rd_ff.first} > nl1) begin
                        emit            = 1'b1;
                        emit_data.first = nf_ff;
                        emit_data.last  = nl_ff;
                        placed_in       = 1'b1;
                        advance         = 1'b0;
                     end else begin
                        if (rd_ff.first < nf_ff) nf_in = rd_ff.first;
                        if (rd_ff.last > nl_ff) nl_in = rd_ff.last;
                     end
                  end
                  OP_SUB: begin
                     if ((rd_ff.last < s_ff) || (rd_ff.first > e_ff)) begin
                        emit = 1'b1;
                     end else if (rd_ff.first < s_ff) begin
                        emit           = 1'b1;
                        emit_data.last = s_ff - 1'b1;
                        advance        = !(rd_ff.last > e_ff);
                     end else if (rd_ff.last > e_ff) begin
                        emit            = 1'b1;
                        emit_data.first = e_ff + 1'b1;
                     end
                  end
                  default: begin
                     if (rd_ff.last >= s_ff) begin
                        advance  = 1'b0;
                        state_in = ST_RESP;
                        if (e_ff < rd_ff.first) begin
                           memb_in = MEMB_NONE;
                        end else if ((s_ff >= rd_ff.first) && (e_ff <= rd_ff.last)) begin
                           memb_in = MEMB_FULL;
                        end else begin
                           memb_in = MEMB_PART;
                        end
                     end
                  end
               endcase
            end
            if (advance) begin
               if (at_end) begin
                  state_in = ST_FINISH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  rd_en    = 1'b1;
                  rd_addr  = {bank_ff, idx_ff + 1'b1};
                  state_in = ST_PROC;
               end
            end else if (state_in != ST_RESP) begin
               state_in = ST_SPLIT;
            end
         end
         ST_FINISH: begin
            if ((op_ff == OP_ADD) && !placed_ff) begin
               emit            = 1'b1;
               emit_data.first = nf_ff;
               emit_data.last  = nl_ff;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.membership = memb_ff;
               rsp_in.table_full = upd_ff && (op_ff != OP_QUERY) && (wcnt_ff > MAX_COUNT);
               if (commit) begin
                  bank_in  = !bank_ff;
                  total_in = wcnt_ff;
                  rsp_in.interval_count = wcnt_ff;
               end else begin
                  rsp_in.interval_count = total_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (emit) begin
         wcnt_in = wcnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
      if (mem_we) begin
         mem[{!bank_ff, wcnt_ff[IDX_BITS-1:0]}] <= emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wcnt_ff   <= wcnt_in;
      idx_ff    <= idx_in;
      op_ff     <= op_in;
      s_ff      <= s_in;
      e_ff      <= e_in;
      nf_ff     <= nf_in;
      nl_ff     <= nl_in;
      placed_ff <= placed_in;
      upd_ff    <= upd_in;
      memb_ff   <= memb_in;
      rsp_ff    <= rsp_in;
   end

   `IST_ASSERT_ALWAYS(a_total_bound, clock, reset, total_ff <= MAX_COUNT, "table over capacity")
   `IST_ASSERT_IMP(a_no_write_idle, clock, reset, state_ff == ST_IDLE, !mem_we, "write while idle")
   `IST_ASSERT_IMP(a_full_no_memb, clock, reset, rsp_valid_ff && rsp_ff.table_full,
      rsp_ff.membership == MEMB_NONE, "refused request with membership")
   `IST_ASSERT_IMP(a_refuse_keeps, clock, reset, state_ff == ST_RESP && !commit,
      ##1 $stable(bank_ff), "bank changed on refusal")

endmodule
